>>> sv/tts_pkg.sv
package tts_pkg;

  localparam int unsigned MaxTasksDef = 8;
  localparam int unsigned ResultLimit = 8;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_DISP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_DEL_EMPTY = 3'd3,
    ST_TICK_DONE = 3'd4,
    ST_RUN       = 3'd5,
    ST_NONE      = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  run_count;
  } slot_entry_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [31:0] tag;
  } result_t;

endpackage

>>> sv/tts_if.sv
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] task_tag;
  logic [15:0] delay;
  logic [15:0] period;
  logic [2:0]  task_slot;

  modport source (output valid, cmd, task_tag, delay, period, task_slot, input ready);
  modport sink (input valid, cmd, task_tag, delay, period, task_slot, output ready);
endinterface

interface tts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  result_slot;
  logic [31:0] result_tag;
  logic        last;

  modport source (output valid, status, result_slot, result_tag, last, input ready);
  modport sink (input valid, status, result_slot, result_tag, last, output ready);
endinterface

>>> sv/tick_task_scheduler_table_core.sv
// Add: first-free scan, one slot a cycle, then the result through S_FIN.
// Delete and disabled tick: no scan; the result is set at accept and leaves from S_FIN.
// Tick (enabled) and dispatch: per slot, a memory read (S_RD) then an update step (S_UPD).
// Dispatch: a result per run slot (ST_NONE if none), at most 8; last at scan end or limit.
// Input is taken only between items, in the cycle after the final result leaves the sequencer.
// Reset (rst_ni low, async) clears valid bits, tick_enable and control; no clearing pass.
module tick_task_scheduler_table_core #(
  parameter int unsigned MAX_TASKS = tts_pkg::MaxTasksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  tts_in_if.sink     in_i,
  tts_out_if.source  out_o
);

  localparam int unsigned SlotW = $clog2(MAX_TASKS);
  localparam int unsigned NW    = $clog2(tts_pkg::ResultLimit + 1);
  localparam logic [SlotW-1:0] LastIdx = SlotW'(MAX_TASKS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_RD   = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic [NW-1:0]         n_q, n_d;
  logic                  held_q, held_d;
  tts_pkg::result_t      fin_q, fin_d;
  logic [MAX_TASKS-1:0]  valid_q, valid_d;
  logic                  tick_en_q;
  tts_pkg::cmd_e         cmd_q, cmd_d;
  logic [31:0]           tag_q, tag_d;
  logic [15:0]           dly_q, dly_d;
  logic [15:0]           per_q, per_d;

  logic                  out_valid_q;
  tts_pkg::status_e      out_status_q;
  logic [2:0]            out_slot_q;
  logic [31:0]           out_tag_q;
  logic                  out_last_q;

  logic                  mem_we, mem_re;
  tts_pkg::slot_entry_t  mem_wdata, mem_rdata, alu_nxt;
  logic                  alu_keep, alu_run;
  logic                  push, push_last, out_free;
  logic                  del_in_range;
  logic [SlotW-1:0]      del_idx;

  tts_slot_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (SlotW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  tts_slot_alu u_alu (
    .tick_i       (cmd_q == tts_pkg::CMD_TICK),
    .valid_i      (valid_q[idx_q]),
    .entry_i      (mem_rdata),
    .entry_o      (alu_nxt),
    .keep_valid_o (alu_keep),
    .run_o        (alu_run)
  );

  assign out_free     = !out_valid_q || out_o.ready;
  assign in_i.ready   = (state_q == S_IDLE);
  assign del_in_range = 32'(in_i.task_slot) < 32'(MAX_TASKS);
  assign del_idx      = SlotW'(in_i.task_slot);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    n_d       = n_q;
    held_d    = held_q;
    fin_d     = fin_q;
    valid_d   = valid_q;
    cmd_d     = cmd_q;
    tag_d     = tag_q;
    dly_d     = dly_q;
    per_d     = per_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = alu_nxt;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d  = tts_pkg::cmd_e'(in_i.cmd);
          tag_d  = in_i.task_tag;
          dly_d  = in_i.delay;
          per_d  = in_i.period;
          idx_d  = '0;
          n_d    = '0;
          held_d = 1'b0;
          unique case (tts_pkg::cmd_e'(in_i.cmd))
            tts_pkg::CMD_ADD: begin
              state_d = S_ADD;
            end
            tts_pkg::CMD_DEL: begin
              fin_d = '{tts_pkg::ST_DEL_EMPTY, in_i.task_slot, 32'd0};
              if (del_in_range) begin
                if (valid_q[del_idx]) begin
                  fin_d.status = tts_pkg::ST_DELETED;
                end
                valid_d[del_idx] = 1'b0;
              end
              state_d = S_FIN;
            end
            tts_pkg::CMD_TICK: begin
              fin_d   = '{tts_pkg::ST_TICK_DONE, 3'd0, 32'd0};
              state_d = tick_en_q ? S_RD : S_FIN;
            end
            tts_pkg::CMD_DISP: begin
              fin_d   = '{tts_pkg::ST_NONE, 3'd0, 32'd0};
              state_d = S_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (!valid_q[idx_q]) begin
          mem_we          = 1'b1;
          mem_wdata       = '{tag_q, dly_q, per_q, 8'd0};
          valid_d[idx_q]  = 1'b1;
          fin_d           = '{tts_pkg::ST_ADDED, 3'(idx_q), 32'd0};
          state_d         = S_FIN;
        end else if (idx_q == LastIdx) begin
          fin_d   = '{tts_pkg::ST_FULL, 3'd0, 32'd0};
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (cmd_q == tts_pkg::CMD_TICK || !alu_run) begin
          mem_we = (cmd_q == tts_pkg::CMD_TICK) && valid_q[idx_q];
          if (idx_q == LastIdx) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + SlotW'(1);
            state_d = S_RD;
          end
        end else if (!held_q || out_free) begin
          push           = held_q;
          mem_we         = 1'b1;
          valid_d[idx_q] = alu_keep;
          fin_d          = '{tts_pkg::ST_RUN, 3'(idx_q), mem_rdata.tag};
          held_d         = 1'b1;
          n_d            = n_q + NW'(1);
          if (n_q == NW'(tts_pkg::ResultLimit - 1) || idx_q == LastIdx) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + SlotW'(1);
            state_d = S_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      held_q      <= 1'b0;
      valid_q     <= '0;
      tick_en_q   <= 1'b0;
      cmd_q       <= tts_pkg::CMD_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      held_q  <= held_d;
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
      if (cfg_we_i) begin
        tick_en_q <= cfg_wdata_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    tag_q <= tag_d;
    dly_q <= dly_d;
    per_q <= per_d;
    if (push) begin
      out_status_q <= fin_q.status;
      out_slot_q   <= fin_q.slot;
      out_tag_q    <= fin_q.tag;
      out_last_q   <= push_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.result_slot = out_slot_q;
  assign out_o.result_tag  = out_tag_q;
  assign out_o.last        = out_last_q;

endmodule

>>> sv/tts_slot_mem.sv
module tts_slot_mem #(
  parameter int unsigned DEPTH = tts_pkg::MaxTasksDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  tts_pkg::slot_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output tts_pkg::slot_entry_t rdata_o
);

  tts_pkg::slot_entry_t mem [DEPTH];
  tts_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tts_slot_alu.sv
module tts_slot_alu (
  input  logic                 tick_i,
  input  logic                 valid_i,
  input  tts_pkg::slot_entry_t entry_i,
  output tts_pkg::slot_entry_t entry_o,
  output logic                 keep_valid_o,
  output logic                 run_o
);

  always_comb begin
    entry_o      = entry_i;
    keep_valid_o = valid_i;
    run_o        = 1'b0;
    if (tick_i) begin
      if (entry_i.delay == 16'd0) begin
        if (entry_i.run_count != 8'hFF) begin
          entry_o.run_count = entry_i.run_count + 8'd1;
        end
        if (entry_i.period != 16'd0) begin
          entry_o.delay = entry_i.period;
        end
      end else begin
        entry_o.delay = entry_i.delay - 16'd1;
      end
    end else begin
      run_o             = valid_i && (entry_i.run_count != 8'd0);
      entry_o.run_count = entry_i.run_count - 8'd1;
      if (run_o && (entry_i.period == 16'd0)) begin
        keep_valid_o = 1'b0;
      end
    end
  end

endmodule

>>> sv/tts_checker.sv
module tts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_status_i,
  input logic       out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after an accepted item");

  a_mid_is_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == 3'(tts_pkg::ST_RUN))
    else $error("non-final result that is not a run");

  a_idle_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("idle with a non-final result pending");

endmodule

bind tick_task_scheduler_table_core tts_checker u_tts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);
